[rtl/prtt_pkg.sv]
// Package for the pending request timeout table: sizes, codes and cell link types.
package prtt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int HANDLE_BITS = 16;
  localparam int SEQ_BITS    = 32;
  localparam int TIME_BITS   = 32;

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_UNUSED = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_PUSH     = 2'd0,
    KIND_POP      = 2'd1,
    KIND_EXPIRY   = 2'd2,
    KIND_TICK_END = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } state_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                   push_go;
    logic                   pop_go;
    logic                   mark_load;
    logic                   emit_go;
    logic                   scan;
    logic [SEQ_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
    logic [TIME_BITS-1:0]   deadline;
    logic [TIME_BITS-1:0]   time_now;
  } cmd_t;

  // Passed from each cell to the next one up the row.
  typedef struct packed {
    logic                   free_seen;
    logic                   mark_seen;
    logic                   hit;
    logic [SEQ_BITS-1:0]    seq;
    logic [HANDLE_BITS-1:0] handle;
  } link_t;

endpackage

[rtl/prtt_cell.sv]
// One table entry: key compare, free and expiry priority, data merge onto the chain.
module prtt_cell
  import prtt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  cmd_t  cmd,
  input  link_t link_in,
  output link_t link_out,
  output logic  busy
);

  logic                   valid;
  logic                   mark;
  logic [SEQ_BITS-1:0]    seq;
  logic [HANDLE_BITS-1:0] handle;
  logic [TIME_BITS-1:0]   deadline;

  logic                   match;
  logic                   first_free;
  logic                   first_mark;
  logic                   pick;
  logic [TIME_BITS-1:0]   gap;

  assign match      = valid && (seq == cmd.key);
  assign first_free = !valid && !link_in.free_seen;
  assign first_mark = mark && !link_in.mark_seen;
  assign pick       = cmd.scan ? first_mark : match;
  assign gap        = deadline - cmd.time_now;
  assign busy       = valid;

  always_comb begin
    link_out.free_seen = link_in.free_seen | ~valid;
    link_out.mark_seen = link_in.mark_seen | mark;
    link_out.hit       = link_in.hit | match;
    link_out.seq       = link_in.seq | (pick ? seq : '0);
    link_out.handle    = link_in.handle | (pick ? handle : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      mark  <= 1'b0;
    end else begin
      if (cmd.push_go && first_free) begin
        valid <= 1'b1;
      end else if (cmd.pop_go && match) begin
        valid <= 1'b0;
      end else if (cmd.emit_go && first_mark) begin
        valid <= 1'b0;
      end
      if (cmd.mark_load) begin
        mark <= valid & gap[TIME_BITS-1];
      end else if (cmd.emit_go && first_mark) begin
        mark <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_go && first_free) begin
      seq      <= cmd.key;
      handle   <= cmd.handle;
      deadline <= cmd.deadline;
    end
  end

endmodule

[rtl/pending_request_timeout_table_top.sv]
// Top level of the pending request timeout table: controller, output register, cell row.
//
// Input stream (s_*): one transfer per request. s_tuser is the action
// (push, pop, tick; code 3 is dropped). A push stores sequence, handle and
// deadline = now + timeout in the lowest free entry unless the sequence is
// already present or the table is full. A pop returns and frees the entry.
// A tick advances the millisecond counter and reports expired entries.
// Output stream (m_*): push and pop give one result each, through the
// request register and then the output register; a new request is taken
// only once the result of the previous one is in the output register. A tick
// gives one expiry notice per expired entry, lowest entry first, one per
// cycle while the receiver does not stall, then a closing result with tlast
// set, and only then is the next request taken. The key compare, free
// search and expiry test run in parallel in the row of entry cells; the
// row resolves priority by a chain from entry 0 upward.
// Reset empties the table and clears the time counter. While the receiver
// stalls, the pending result holds in the output register and the block
// stops at the next result it would produce.
module pending_request_timeout_table_top
  import prtt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // action
  input  logic [79:0] s_tdata,   // sequence_req[31:0], handle[47:32], timeout_ms[79:48]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [1:0]  m_tuser,   // kind
  output logic [55:0] m_tdata,   // ok[0], seq_out[32:1], handle_out[48:33], zero[55:49]
  output logic        m_tlast
);

  state_t                 state;
  state_t                 state_next;
  action_t                req_action;
  logic [SEQ_BITS-1:0]    req_seq;
  logic [HANDLE_BITS-1:0] req_handle;
  logic [TIME_BITS-1:0]   req_tmo;
  logic [TIME_BITS-1:0]   time_now;

  logic                   out_valid;
  kind_t                  out_kind;
  logic                   out_ok;
  logic [SEQ_BITS-1:0]    out_seq;
  logic [HANDLE_BITS-1:0] out_handle;
  logic                   out_last;

  logic                   out_set;
  kind_t                  out_kind_next;
  logic                   out_ok_next;
  logic [SEQ_BITS-1:0]    out_seq_next;
  logic [HANDLE_BITS-1:0] out_handle_next;
  logic                   out_last_next;

  logic                   out_load;
  logic                   in_fire;
  cmd_t                   cmd;
  link_t                  chain [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] busy;

  assign out_load = !out_valid || m_tready;
  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign chain[0] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    prtt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .link_in  (chain[i]),
      .link_out (chain[i+1]),
      .busy     (busy[i])
    );
  end

  always_comb begin
    cmd.push_go   = (state == ST_EXEC) && (req_action == ACT_PUSH) && out_load &&
                    !chain[TABLE_DEPTH].hit && chain[TABLE_DEPTH].free_seen;
    cmd.pop_go    = (state == ST_EXEC) && (req_action == ACT_POP) && out_load;
    cmd.mark_load = (state == ST_EXEC) && (req_action == ACT_TICK);
    cmd.emit_go   = (state == ST_SCAN) && out_load;
    cmd.scan      = (state == ST_SCAN);
    cmd.key       = req_seq;
    cmd.handle    = req_handle;
    cmd.deadline  = time_now + req_tmo;
    cmd.time_now  = time_now;
  end

  always_comb begin
    state_next      = state;
    out_set         = 1'b0;
    out_kind_next   = KIND_PUSH;
    out_ok_next     = 1'b0;
    out_seq_next    = req_seq;
    out_handle_next = '0;
    out_last_next   = 1'b1;
    case (state)
      ST_IDLE: begin
        if (in_fire && (s_tuser != ACT_UNUSED)) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (req_action)
          ACT_PUSH: begin
            if (out_load) begin
              out_set     = 1'b1;
              out_ok_next = !chain[TABLE_DEPTH].hit && chain[TABLE_DEPTH].free_seen;
              state_next  = ST_IDLE;
            end
          end
          ACT_POP: begin
            if (out_load) begin
              out_set         = 1'b1;
              out_kind_next   = KIND_POP;
              out_ok_next     = chain[TABLE_DEPTH].hit;
              out_handle_next = chain[TABLE_DEPTH].handle;
              state_next      = ST_IDLE;
            end
          end
          ACT_TICK: begin
            state_next = ST_SCAN;
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_SCAN: begin
        if (out_load) begin
          out_set = 1'b1;
          if (chain[TABLE_DEPTH].mark_seen) begin
            out_kind_next   = KIND_EXPIRY;
            out_seq_next    = chain[TABLE_DEPTH].seq;
            out_handle_next = chain[TABLE_DEPTH].handle;
            out_last_next   = 1'b0;
          end else begin
            out_kind_next = KIND_TICK_END;
            out_seq_next  = '0;
            state_next    = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire && (s_tuser == ACT_TICK)) begin
        time_now <= time_now + 1'b1;
      end
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_action <= action_t'(s_tuser);
      req_seq    <= s_tdata[31:0];
      req_handle <= s_tdata[47:32];
      req_tmo    <= s_tdata[79:48];
    end
    if (out_set) begin
      out_kind   <= out_kind_next;
      out_ok     <= out_ok_next;
      out_seq    <= out_seq_next;
      out_handle <= out_handle_next;
      out_last   <= out_last_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = {7'd0, out_handle, out_seq, out_ok};
  assign m_tlast  = out_last;

  a_scan_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) && out_load && !chain[TABLE_DEPTH].mark_seen |=> (state == ST_IDLE))
    else $error("scan did not finish after the last expiry");

  a_pop_frees: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_go && chain[TABLE_DEPTH].hit |=>
      ($countones(busy) == $past($countones(busy)) - 1))
    else $error("pop hit did not free exactly one entry");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    cmd.push_go |=> ($countones(busy) == $past($countones(busy)) + 1))
    else $error("push did not fill exactly one entry");

  a_emit_frees: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_go && chain[TABLE_DEPTH].mark_seen |=>
      ($countones(busy) == $past($countones(busy)) - 1))
    else $error("expiry notice did not free exactly one entry");

endmodule

[dv/tb_top.sv]
// Testbench for the pending request timeout table: stream driver, result monitor, table predictor.
`timescale 1ns / 1ps

module tb_top;
  import prtt_pkg::*;

  typedef struct packed {
    action_t                action;
    logic [SEQ_BITS-1:0]    seq;
    logic [HANDLE_BITS-1:0] handle;
    logic [TIME_BITS-1:0]   timeout;
  } request_t;

  typedef struct packed {
    kind_t                  kind;
    logic                   ok;
    logic [SEQ_BITS-1:0]    seq;
    logic [HANDLE_BITS-1:0] handle;
    logic                   last;
  } answer_t;

  localparam int RANDOM_ITEMS = 345;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [1:0]  s_tuser = ACT_PUSH;
  logic [79:0] s_tdata = '0;   // sequence_req[31:0], handle[47:32], timeout_ms[79:48]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [1:0]  m_tuser;        // kind
  logic [55:0] m_tdata;        // ok[0], seq_out[32:1], handle_out[48:33], zero[55:49]
  logic        m_tlast;

  request_t requests[$];
  request_t on_bus;
  answer_t  answers_due[$];
  logic     in_taken = 1'b0;
  int       total_items;
  int       sent_count;
  int       mismatches;

  // table mirror
  logic                   busy[TABLE_DEPTH];
  logic [SEQ_BITS-1:0]    key_at[TABLE_DEPTH];
  logic [HANDLE_BITS-1:0] tag_at[TABLE_DEPTH];
  logic [TIME_BITS-1:0]   due_at[TABLE_DEPTH];
  logic [TIME_BITS-1:0]   now_ms;

  pending_request_timeout_table_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic add_request(input action_t act, input logic [SEQ_BITS-1:0] seq,
                             input logic [HANDLE_BITS-1:0] hnd,
                             input logic [TIME_BITS-1:0] tmo);
    requests.push_back('{action: act, seq: seq, handle: hnd, timeout: tmo});
  endtask

  task automatic table_update(input request_t r);
    int slot;
    int hit;
    logic [TIME_BITS-1:0] left;
    slot = -1;
    hit = -1;
    case (r.action)
      ACT_PUSH: begin
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (busy[i] && key_at[i] == r.seq) hit = i;
        if (hit < 0)
          for (int i = TABLE_DEPTH - 1; i >= 0; i--)
            if (!busy[i]) slot = i;
        if (slot >= 0) begin
          busy[slot]   = 1'b1;
          key_at[slot] = r.seq;
          tag_at[slot] = r.handle;
          due_at[slot] = now_ms + r.timeout;
        end
        answers_due.push_back('{kind: KIND_PUSH, ok: (slot >= 0), seq: r.seq,
                                handle: '0, last: 1'b1});
      end
      ACT_POP: begin
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (busy[i] && key_at[i] == r.seq) hit = i;
        if (hit >= 0) begin
          busy[hit] = 1'b0;
          answers_due.push_back('{kind: KIND_POP, ok: 1'b1, seq: r.seq,
                                  handle: tag_at[hit], last: 1'b1});
        end else begin
          answers_due.push_back('{kind: KIND_POP, ok: 1'b0, seq: r.seq,
                                  handle: '0, last: 1'b1});
        end
      end
      ACT_TICK: begin
        now_ms = now_ms + 1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (busy[i]) begin
            left = due_at[i] - now_ms;
            if (left[TIME_BITS-1]) begin
              answers_due.push_back('{kind: KIND_EXPIRY, ok: 1'b0, seq: key_at[i],
                                      handle: tag_at[i], last: 1'b0});
              busy[i] = 1'b0;
            end
          end
        end
        answers_due.push_back('{kind: KIND_TICK_END, ok: 1'b0, seq: '0,
                                handle: '0, last: 1'b1});
      end
      default: ;
    endcase
  endtask

  task automatic check_answer();
    answer_t want;
    if (answers_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind=%0d data=%h", m_tuser, m_tdata));
    end else begin
      want = answers_due.pop_front();
      if (m_tuser !== want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", m_tuser, want.kind));
      if (m_tdata[0] !== want.ok)
        report_mismatch($sformatf("ok %b, want %b (seq %h)", m_tdata[0], want.ok, want.seq));
      if (m_tdata[32:1] !== want.seq)
        report_mismatch($sformatf("seq %h, want %h", m_tdata[32:1], want.seq));
      if (m_tdata[48:33] !== want.handle)
        report_mismatch($sformatf("handle %h, want %h (seq %h)", m_tdata[48:33],
                                  want.handle, want.seq));
      if (m_tlast !== want.last)
        report_mismatch($sformatf("last %b, want %b (seq %h)", m_tlast, want.last, want.seq));
    end
  endtask

  function automatic int send_idle_pct();
    if (sent_count < total_items / 3) return 9;
    if (sent_count < 2 * total_items / 3) return 85;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (sent_count < total_items / 3) return 85;
    if (sent_count < 2 * total_items / 3) return 9;
    return 0;
  endfunction

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) check_answer();
      if (s_tvalid && s_tready) table_update(on_bus);
      in_taken <= s_tvalid && s_tready;
    end
  end

  // driver
  always @(negedge clk) begin : drive
    logic go;
    request_t nxt;
    if (!rst) begin
      if (!s_tvalid || in_taken) begin
        go = requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct();
        if (go) begin
          nxt = requests.pop_front();
          on_bus <= nxt;
          s_tuser <= nxt.action;
          s_tdata <= {nxt.timeout, nxt.handle, nxt.seq};
          sent_count++;
        end
        s_tvalid <= go;
      end
      m_tready <= $urandom_range(0, 99) >= recv_idle_pct();
    end
  end

  initial begin : stimulus
    logic [SEQ_BITS-1:0] pool[$];
    logic [SEQ_BITS-1:0] seq;
    logic [TIME_BITS-1:0] tmo;
    int pick;
    int made;

    for (int i = 0; i < TABLE_DEPTH; i++) busy[i] = 1'b0;
    now_ms = '0;
    sent_count = 0;
    mismatches = 0;

    // directed part
    add_request(ACT_PUSH, 32'h0, 16'h0, 32'h0);
    add_request(ACT_PUSH, 32'h0, 16'h1234, 32'h5);          // duplicate
    add_request(ACT_PUSH, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    add_request(ACT_POP, 32'h0, 16'h0, 32'h0);              // hit
    add_request(ACT_POP, 32'h0, 16'hFFFF, 32'hFFFF_FFFF);   // miss
    add_request(ACT_TICK, 32'h0, 16'h0, 32'h0);             // deadline behind now
    add_request(ACT_UNUSED, 32'hDEAD_BEEF, 16'hBEEF, 32'h1);
    for (int i = 0; i < TABLE_DEPTH; i++)
      add_request(ACT_PUSH, 32'h100 + i, 16'h1 << i, 32'h0);
    add_request(ACT_PUSH, 32'hCAFE_0001, 16'hAAAA, 32'h10); // table full
    add_request(ACT_TICK, 32'hFFFF_FFFF, 16'hFFFF, 32'h0);  // every entry expires

    // random part
    made = 0;
    while (made < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        if (pool.size() > 0 && $urandom_range(0, 99) < 20)
          seq = pool[$urandom_range(0, pool.size() - 1)];
        else
          seq = $urandom;
        case ($urandom_range(0, 9))
          0:       tmo = $urandom;
          1:       tmo = 32'h7FFF_FFFF + $urandom_range(0, 2) - 1;
          2:       tmo = 32'hFFFF_FFFF - $urandom_range(0, 3);
          default: tmo = $urandom_range(0, 20);
        endcase
        add_request(ACT_PUSH, seq, HANDLE_BITS'($urandom), tmo);
        pool.push_back(seq);
        if (pool.size() > 32) void'(pool.pop_front());
        made++;
      end else if (pick < 80) begin
        if (pool.size() > 0 && $urandom_range(0, 99) < 75)
          seq = pool[$urandom_range(0, pool.size() - 1)];
        else
          seq = $urandom;
        add_request(ACT_POP, seq, HANDLE_BITS'($urandom), $urandom);
        made++;
      end else if (pick < 95) begin
        add_request(ACT_TICK, $urandom, HANDLE_BITS'($urandom), $urandom);
        made++;
      end else begin
        add_request(ACT_UNUSED, $urandom, HANDLE_BITS'($urandom), $urandom);
      end
    end
    total_items = requests.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (requests.size() != 0 || s_tvalid) @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
